### src/b64t_pkg.sv
// Shared types, constants and alphabet functions for the base64url token codec.
package b64t_pkg;

   localparam logic       DIR_ENCODE     = 1'b0;
   localparam logic       DIR_DECODE     = 1'b1;

   localparam logic [5:0] ENC_FINAL_POS  = 6'd31;
   localparam logic [5:0] DEC_FINAL_POS  = 6'd42;
   localparam logic [5:0] DEC_GROUP_END  = 6'd40;

   typedef enum logic [2:0] {
      JOB_ERROR = 3'd0,
      JOB_ENC4  = 3'd1,
      JOB_ENC3  = 3'd2,
      JOB_DEC3  = 3'd3,
      JOB_DEC2  = 3'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [23:0]  acc;
      logic         ok;
   } job_type;

   function automatic logic [2:0] job_len(input job_kind_type kind);
      logic [2:0] n;
      unique case (kind)
         JOB_ERROR: n = 3'd1;
         JOB_ENC4:  n = 3'd4;
         JOB_ENC3:  n = 3'd3;
         JOB_DEC3:  n = 3'd3;
         JOB_DEC2:  n = 3'd2;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2D;
      end else begin
         c = 8'h5F;
      end
      return c;
   endfunction

   // bit 6 set when the character belongs to the alphabet
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2D) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h5F) begin
         r = {1'b1, 6'd63};
      end else begin
         r = 7'd0;
      end
      return r;
   endfunction

endpackage

### src/b64t_front.sv
// Front end: accepts items, tracks token position and packs groups into jobs.
module b64t_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_symbol,
   input  logic             req_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_direction,
   input  logic             queue_full,
   output logic             push,
   output b64t_pkg::job_type push_job
);
   import b64t_pkg::*;

   logic        dir_ff, dir_in;
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  phase_ff, phase_in;
   logic        bad_ff, bad_in;
   logic        discard_ff, discard_in;
   logic        accept;
   logic [5:0]  final_pos;
   logic [6:0]  sext;
   logic        job_valid;
   job_type     job;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & ~queue_full;
   assign final_pos = dir_ff ? DEC_FINAL_POS : ENC_FINAL_POS;
   assign sext      = char_to_sextet(req_symbol);

   always_comb begin
      dir_in     = dir_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      bad_in     = bad_ff;
      discard_in = discard_ff;
      job_valid  = 1'b0;
      job.kind   = JOB_ERROR;
      job.acc    = '0;
      job.ok     = 1'b0;
      if (csr_valid) begin
         dir_in     = csr_direction;
         acc_in     = '0;
         pos_in     = '0;
         phase_in   = '0;
         bad_in     = 1'b0;
         discard_in = 1'b0;
      end else if (accept) begin
         if (discard_ff || (req_last && pos_ff < final_pos)) begin
            if (req_last) begin
               job_valid  = 1'b1;
               acc_in     = '0;
               pos_in     = '0;
               phase_in   = '0;
               bad_in     = 1'b0;
               discard_in = 1'b0;
            end
         end else if (!req_last && pos_ff >= final_pos) begin
            discard_in = 1'b1;
         end else begin
            pos_in   = pos_ff + 6'd1;
            phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            if (!dir_ff) begin
               acc_in = {acc_ff[15:0], req_symbol};
            end else begin
               acc_in = {acc_ff[17:0], sext[5:0]};
               bad_in = bad_ff | ~sext[6];
            end
            job.acc = acc_in;
            if (pos_ff == final_pos) begin
               job_valid  = 1'b1;
               job.kind   = dir_ff ? JOB_DEC2 : JOB_ENC3;
               job.ok     = ~bad_in;
               acc_in     = '0;
               pos_in     = '0;
               phase_in   = '0;
               bad_in     = 1'b0;
            end else if (!dir_ff && phase_ff == 2'd2) begin
               job_valid = 1'b1;
               job.kind  = JOB_ENC4;
            end else if (dir_ff && pos_ff < DEC_GROUP_END && pos_ff[1:0] == 2'd3) begin
               job_valid = 1'b1;
               job.kind  = JOB_DEC3;
            end
         end
      end
   end

   assign push     = accept & job_valid & ~csr_valid;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= 1'b0;
         acc_ff     <= '0;
         pos_ff     <= '0;
         phase_ff   <= '0;
         bad_ff     <= 1'b0;
         discard_ff <= 1'b0;
      end else begin
         dir_ff     <= dir_in;
         acc_ff     <= acc_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         bad_ff     <= bad_in;
         discard_ff <= discard_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= DEC_FINAL_POS)
      else $error("position ran past the final character");

endmodule

### src/b64t_queue.sv
// Job queue between the front end and the result sequencer.
module b64t_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64t_pkg::job_type push_job,
   input  logic              pop,
   output b64t_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);
   import b64t_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign empty    = (count_ff == CW'(0));
   assign full     = (count_ff == CW'(DEPTH));
   assign head_job = mem[rd_ptr_ff];
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

endmodule

### src/b64t_back.sv
// Back end: expands queued jobs into result items through an output register.
module b64t_back (
   input  logic              clock,
   input  logic              reset,
   input  b64t_pkg::job_type head_job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_symbol,
   output logic              rsp_out_last,
   output logic              rsp_token_ok
);
   import b64t_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] sym_ff, sym_in;
   logic       last_ff, last_in;
   logic       ok_ff, ok_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       final_step;
   logic [2:0] len;
   logic [23:0] a;

   assign load       = (~valid_ff | ~rsp_stall) & ~empty;
   assign len        = job_len(head_job.kind);
   assign final_step = ({1'b0, idx_ff} == len - 3'd1);
   assign pop        = load & final_step;
   assign a          = head_job.acc;

   always_comb begin
      sym_in  = sym_ff;
      last_in = last_ff;
      ok_in   = ok_ff;
      idx_in  = idx_ff;
      valid_in = valid_ff & rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_step ? 2'd0 : idx_ff + 2'd1;
         last_in  = 1'b0;
         ok_in    = 1'b0;
         unique case (head_job.kind)
            JOB_ENC4: begin
               case (idx_ff)
                  2'd0:    sym_in = sextet_to_char(a[23:18]);
                  2'd1:    sym_in = sextet_to_char(a[17:12]);
                  2'd2:    sym_in = sextet_to_char(a[11:6]);
                  default: sym_in = sextet_to_char(a[5:0]);
               endcase
            end
            JOB_ENC3: begin
               case (idx_ff)
                  2'd0:    sym_in = sextet_to_char(a[15:10]);
                  2'd1:    sym_in = sextet_to_char(a[9:4]);
                  default: sym_in = sextet_to_char({a[3:0], 2'b00});
               endcase
               last_in = final_step;
               ok_in   = final_step & head_job.ok;
            end
            JOB_DEC3: begin
               case (idx_ff)
                  2'd0:    sym_in = a[23:16];
                  2'd1:    sym_in = a[15:8];
                  default: sym_in = a[7:0];
               endcase
            end
            JOB_DEC2: begin
               sym_in  = (idx_ff == 2'd0) ? a[17:10] : a[9:2];
               last_in = final_step;
               ok_in   = final_step & head_job.ok;
            end
            default: begin
               sym_in  = 8'd0;
               last_in = 1'b1;
               ok_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      sym_ff  <= sym_in;
      last_ff <= last_in;
      ok_ff   <= ok_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_symbol = sym_ff;
   assign rsp_out_last   = last_ff;
   assign rsp_token_ok   = ok_ff;

   a_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && ok_ff |-> last_ff)
      else $error("token_ok raised on a non-final item");

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, idx_ff} < len))
      else $error("result index beyond job length");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      empty |-> idx_ff == 2'd0)
      else $error("partial job left when queue is empty");

endmodule

### src/base64url_token_codec.sv
// Top level of the base64url token codec: front end, job queue and result sequencer.
// Encodes a 32-byte token to 43 unpadded base64url characters (direction 0) or decodes
// 43 characters back to 32 bytes (direction 1). Input items are taken one per cycle
// while the job queue has room; the result sequencer delivers one result item per cycle
// while results are queued and the output is not stalled, so the output side sets the
// sustained rate when encoding. The first result of a group is written to the job queue
// by the edge that accepts the item completing the group and reaches the result port
// through the output register. The final result of each token carries token_ok; a token
// of the wrong length ends in a single zero result with token_ok low.
// A direction write clears all token state and must be issued only while idle.
module base64url_token_codec #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_out_last,
   output logic       rsp_token_ok,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_direction
);
   import b64t_pkg::*;

   logic    push, pop, empty, full;
   job_type push_job, head_job;

   b64t_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_symbol    (req_symbol),
      .req_last      (req_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_direction (csr_direction),
      .queue_full    (full),
      .push          (push),
      .push_job      (push_job)
   );

   b64t_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   b64t_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .rsp_token_ok   (rsp_token_ok)
   );

endmodule

### dv/base64url_token_codec_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the base64url token codec: predicts every result item and checks the output.
module base64url_token_codec_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_symbol,
   input  logic       rsp_out_last,
   input  logic       rsp_token_ok,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_direction,
   output int         symbols_owed,
   output int         mismatches
);
   import b64t_pkg::*;

   localparam logic [8*64-1:0] URL_SAFE_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic       ok;
   } codec_result_type;

   codec_result_type expected_symbols[$];
   codec_result_type want;
   logic          direction;
   logic [23:0]   group;
   logic [5:0]    pos;
   logic          bad_seen;
   logic          dropping;

   function automatic logic [7:0] char_of(input logic [5:0] v);
      return URL_SAFE_ALPHABET[8*(63 - v) +: 8];
   endfunction

   // bit 6 flags a character of the alphabet
   function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
         if (char_of(6'(i)) == c) begin
            return {1'b1, 6'(i)};
         end
      end
      return 7'd0;
   endfunction

   task automatic clear_token();
      group    = 24'd0;
      pos      = 6'd0;
      bad_seen = 1'b0;
      dropping = 1'b0;
   endtask

   task automatic owe(input logic [7:0] s, input logic l, input logic ok);
      expected_symbols.push_back('{symbol: s, last: l, ok: ok});
   endtask

   task automatic codec_step(input logic [7:0] s, input logic l);
      logic [5:0] last_pos;
      logic [6:0] lookup;
      last_pos = (direction == DIR_DECODE) ? DEC_FINAL_POS : ENC_FINAL_POS;
      if (dropping) begin
         if (l) begin
            owe(8'h00, 1'b1, 1'b0);
            clear_token();
         end
      end else if (l && pos < last_pos) begin
         owe(8'h00, 1'b1, 1'b0);
         clear_token();
      end else if (!l && pos >= last_pos) begin
         dropping = 1'b1;
      end else if (direction == DIR_ENCODE) begin
         group = {group[15:0], s};
         if (pos == last_pos) begin
            owe(char_of(group[15:10]), 1'b0, 1'b0);
            owe(char_of(group[9:4]), 1'b0, 1'b0);
            owe(char_of({group[3:0], 2'b00}), 1'b1, 1'b1);
            clear_token();
         end else begin
            if ((pos % 6'd3) == 6'd2) begin
               owe(char_of(group[23:18]), 1'b0, 1'b0);
               owe(char_of(group[17:12]), 1'b0, 1'b0);
               owe(char_of(group[11:6]), 1'b0, 1'b0);
               owe(char_of(group[5:0]), 1'b0, 1'b0);
            end
            pos = pos + 6'd1;
         end
      end else begin
         lookup = sextet_lookup(s);
         if (!lookup[6]) begin
            bad_seen = 1'b1;
         end
         group = {group[17:0], lookup[5:0]};
         if (pos == last_pos) begin
            owe(group[17:10], 1'b0, 1'b0);
            owe(group[9:2], 1'b1, !bad_seen);
            clear_token();
         end else begin
            if (pos < DEC_GROUP_END && pos[1:0] == 2'b11) begin
               owe(group[23:16], 1'b0, 1'b0);
               owe(group[15:8], 1'b0, 1'b0);
               owe(group[7:0], 1'b0, 1'b0);
            end
            pos = pos + 6'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatches = 0;
         direction  = DIR_ENCODE;
         clear_token();
         expected_symbols.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected item symbol %h last %b ok %b", $time,
                        rsp_out_symbol, rsp_out_last, rsp_token_ok);
               mismatches++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_out_symbol !== want.symbol) begin
                  $display("%0t: out_symbol expected %h actual %h", $time,
                           want.symbol, rsp_out_symbol);
                  mismatches++;
               end
               if (rsp_out_last !== want.last) begin
                  $display("%0t: out_last expected %b actual %b", $time,
                           want.last, rsp_out_last);
                  mismatches++;
               end
               if (rsp_token_ok !== want.ok) begin
                  $display("%0t: token_ok expected %b actual %b", $time,
                           want.ok, rsp_token_ok);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            direction = csr_direction;
            clear_token();
         end
         if (req_valid && !req_stall) begin
            codec_step(req_symbol, req_last);
         end
      end
      symbols_owed <= expected_symbols.size();
   end

endmodule

### dv/base64url_token_codec_tb.sv
`timescale 1ns / 1ps
// Testbench top for the base64url token codec: token stimulus, direction writes and verdict.
module base64url_token_codec_tb;
   import b64t_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ITEMS_PER_PASS = 100;

   typedef enum int {
      TOK_GOOD,
      TOK_BAD_CHAR,
      TOK_SHORT,
      TOK_LONG,
      TOK_NOISE
   } token_shape_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_symbol;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_symbol;
   logic       rsp_out_last;
   logic       rsp_token_ok;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_direction;

   int   symbols_owed;
   int   mismatches;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   logic mode = DIR_ENCODE;

   base64url_token_codec u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .rsp_token_ok   (rsp_token_ok),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_direction  (csr_direction)
   );

   base64url_token_codec_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .rsp_token_ok   (rsp_token_ok),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_direction  (csr_direction),
      .symbols_owed   (symbols_owed),
      .mismatches     (mismatches)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("base64url_token_codec_tb: FAIL");
         $finish;
      end
   end

   // hold valid over a stall; drop it only on an idle cycle
   task automatic push_item(input logic [7:0] s, input logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= s;
      req_last   <= l;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (symbols_owed != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_direction(input logic d);
      wait_drained();
      csr_valid     <= 1'b1;
      csr_direction <= d;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      mode = d;
   endtask

   task automatic send_token(input token_shape_type shape);
      int         len;
      int         n;
      logic [7:0] s;
      logic       l;
      len = (mode == DIR_DECODE) ? int'(DEC_FINAL_POS) + 1 : int'(ENC_FINAL_POS) + 1;
      case (shape)
         TOK_SHORT: n = $urandom_range(len - 1, 1);
         TOK_LONG:  n = len + $urandom_range(6, 1);
         TOK_NOISE: n = $urandom_range(8, 1);
         default:   n = len;
      endcase
      for (int i = 0; i < n; i++) begin
         if (mode == DIR_ENCODE) begin
            s = 8'($urandom_range(255));
         end else if ((shape == TOK_BAD_CHAR || shape == TOK_NOISE) && $urandom_range(5) == 0) begin
            s = 8'($urandom_range(255));
         end else begin
            s = sextet_to_char(6'($urandom_range(63)));
         end
         l = (shape == TOK_NOISE) ? ($urandom_range(3) == 0) : (i == n - 1);
         push_item(s, l);
      end
   endtask

   initial begin
      token_shape_type shape;
      int           pick;
      int           target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_symbol    = 8'h00;
      req_last      = 1'b0;
      csr_valid     = 1'b0;
      csr_direction = DIR_ENCODE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct  = 25;
      rsp_stall_pct = 49;

      // directed: one full group encoding, two decoding, bad characters, short tokens
      set_direction(DIR_ENCODE);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h7F, 1'b0);
      push_item(8'h80, 1'b0);
      push_item(8'h01, 1'b1);
      push_item(8'hAA, 1'b1);
      set_direction(DIR_DECODE);
      push_item("A", 1'b0);
      push_item("_", 1'b0);
      push_item("-", 1'b0);
      push_item("z", 1'b0);
      push_item("0", 1'b0);
      push_item("9", 1'b0);
      push_item("Z", 1'b0);
      push_item("a", 1'b0);
      push_item(8'h2A, 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(8'h00, 1'b1);

      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               req_idle_pct  = 25;
               rsp_stall_pct = 49;
            end
            1: begin
               req_idle_pct  = 49;
               rsp_stall_pct = 25;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         target = items_sent + ITEMS_PER_PASS;
         while (items_sent < target) begin
            if ($urandom_range(2) == 0) begin
               set_direction(!mode);
            end
            pick = $urandom_range(9);
            if (pick < 4) begin
               shape = TOK_GOOD;
            end else if (pick == 4) begin
               shape = TOK_BAD_CHAR;
            end else if (pick < 7) begin
               shape = TOK_SHORT;
            end else if (pick == 7) begin
               shape = TOK_LONG;
            end else begin
               shape = TOK_NOISE;
            end
            send_token(shape);
         end
      end

      wait_drained();
      if (mismatches == 0 && symbols_owed == 0) begin
         $display("base64url_token_codec_tb: PASS");
      end else begin
         $display("base64url_token_codec_tb: FAIL");
      end
      $finish;
   end

endmodule

### files.f
src/b64t_pkg.sv
src/b64t_front.sv
src/b64t_queue.sv
src/b64t_back.sv
src/base64url_token_codec.sv
dv/base64url_token_codec_checker.sv
dv/base64url_token_codec_tb.sv
